// ===== hdl/rgbconv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbconv_pkg: shared types and constants of the rgb 3x3 convolution filter
// Register indexes, reset values and the per-pixel control record.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbconv_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MID    = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_idx_t;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 48;

  // reset values: 1/16 1/8 1/16, 1/8 1/4 1/8, 1/16 1/8 1/16 in Q8.8
  localparam logic [47:0] KERNEL_TOP_RST    = 48'd68721573904;
  localparam logic [47:0] KERNEL_MID_RST    = 48'd137443147808;
  localparam logic [47:0] KERNEL_BOTTOM_RST = 48'd68721573904;
  localparam logic [10:0] IMAGE_WIDTH_RST   = 11'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST  = 12'd480;

  localparam logic [23:0] WHITE_RGB = 24'hFF_FFFF;

  // emit mask bit positions, in raster order of the results
  localparam int EMIT_FILTERED  = 0;  // (r-1, c-1)
  localparam int EMIT_RIGHT_COL = 1;  // (r-1, c)
  localparam int EMIT_BOTTOM    = 2;  // (r, c-1)
  localparam int EMIT_CORNER    = 3;  // (r, c), frame end

  // control record carried beside each pixel through the pipeline
  typedef struct packed {
    logic [3:0]  emit;
    logic        interior;
    logic [11:0] row;
    logic [11:0] row_m1;
    logic [9:0]  col;
    logic [9:0]  col_m1;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/rgbconv_ram.sv =====
// ----------------------------------------------------------------------------
// rgbconv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbconv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rgb_3x3_convolution.sv =====
// ----------------------------------------------------------------------------
// rgb_3x3_convolution: streaming 3x3 kernel filter over rgb raster frames
// Two line stores and a two-column window feed a programmable Q8.8 kernel;
// output pixel (r-1, c-1) follows input (r, c), border pixels are white.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata: red, green, blue
//  out_    | master    | tdata: red, green, blue, row, col; tlast: frame end
//  cfg_    | write     | addr: register index, wr_data: register value
//
//  one request per clock while the output register keeps up; the input register
//  loads beside the line store read; products, nine-tap sum and clamp run in one
//  pass into the output register, which gets a request's first result as the
//  request leaves the input register; an input at the last column or last row
//  gives up to 4 results, leaving one per cycle while out_tready is high; the input
//  register holds meanwhile; synchronous active-low reset; line stores are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_3x3_convolution #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input pixels
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,   // red, green, blue
  // filtered pixels
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [47:0]                     out_tdata,  // red, green, blue, row, col
  output logic                                 out_tlast,  // frame_last
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [rgbconv_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [rgbconv_pkg::CFG_DW-1:0]  cfg_wr_data
);

  import rgbconv_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

  // configuration registers
  logic [47:0] k_top_r, k_mid_r, k_bot_r;
  logic [10:0] width_r;
  logic [11:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r  <= KERNEL_TOP_RST;
      k_mid_r  <= KERNEL_MID_RST;
      k_bot_r  <= KERNEL_BOTTOM_RST;
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_KERNEL_TOP:    k_top_r  <= cfg_wr_data;
        CFG_KERNEL_MID:    k_mid_r  <= cfg_wr_data;
        CFG_KERNEL_BOTTOM: k_bot_r  <= cfg_wr_data;
        CFG_IMAGE_WIDTH:   width_r  <= cfg_wr_data[10:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_wr_data[11:0];
        default: ;
      endcase
    end
  end

  // pipeline state
  logic                      s1_v_r;
  ctl_t                      s1_ctl_r, ob_ctl_r;
  logic [23:0]               s1_px_r;
  logic [CW-1:0]             s1_addr_r;
  logic [3:0]                ob_m_r, ob_m_nxt, ob_m_left;
  logic [23:0]               ob_rgb_r, ob_rgb_nxt;
  logic [23:0]               win_r [6];
  logic [CW-1:0]             col_r;
  logic [11:0]               row_r;

  logic en1, ob_free, in_fire, out_fire, s1_mv;
  logic [47:0] ram_q;

  // stall chain: the input register loads when empty or when it moves on
  always_comb begin
    out_fire  = out_tvalid && out_tready;
    ob_m_left = out_fire ? (ob_m_r & (ob_m_r - 4'd1)) : ob_m_r;
    ob_free   = (ob_m_left == 4'd0);
    en1       = !s1_v_r || ob_free;
    in_tready = en1;
    in_fire   = in_tvalid && en1;
    s1_mv     = s1_v_r && ob_free;
  end

  // frame geometry and position flags
  logic [EW-1:0] w_ext, w_lim;
  logic [11:0]   h_lim;
  logic          last_col, last_row;
  ctl_t          ctl_in;

  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext < EW'(2)) begin
      w_lim = EW'(2);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_lim = EW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    h_lim    = (height_r < 12'd2) ? 12'd2 : height_r;
    last_col = EW'(col_r) >= (w_lim - EW'(1));
    last_row = row_r >= (h_lim - 12'd1);

    ctl_in.emit[EMIT_FILTERED]  = (row_r != 12'd0) && (col_r != '0);
    ctl_in.emit[EMIT_RIGHT_COL] = (row_r != 12'd0) && last_col;
    ctl_in.emit[EMIT_BOTTOM]    = last_row && (col_r != '0);
    ctl_in.emit[EMIT_CORNER]    = last_row && last_col;
    ctl_in.interior = (row_r >= 12'd2) && (EW'(col_r) >= EW'(2));
    ctl_in.row      = row_r;
    ctl_in.row_m1   = row_r - 12'd1;
    ctl_in.col      = 10'(col_r);
    ctl_in.col_m1   = 10'(col_r - CW'(1));
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? 12'd0 : row_r + 12'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line stores: older row in the upper half, newer row in the lower half
  rgbconv_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_mv),
    .waddr (s1_addr_r),
    .wdata ({ram_q[23:0], s1_px_r}),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (ram_q)
  );

  // stage 1: pixel register beside the line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      s1_addr_r <= col_r;
      s1_ctl_r  <= ctl_in;
    end
  end

  // window of the two previous columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_mv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= ram_q[47:24];
      win_r[4] <= ram_q[23:0];
      win_r[5] <= s1_px_r;
    end
  end

  // kernel products, one per tap and channel
  logic [23:0]        tap [3][3];
  logic [47:0]        krow [3];
  logic signed [24:0] prod [3][3][3];

  always_comb begin
    krow[0] = k_top_r;
    krow[1] = k_mid_r;
    krow[2] = k_bot_r;
    tap[0][2] = ram_q[47:24];
    tap[1][2] = ram_q[23:0];
    tap[2][2] = s1_px_r;
    for (int y = 0; y < 3; y++) begin
      tap[y][0] = win_r[y];
      tap[y][1] = win_r[3 + y];
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          prod[ch][y][x] = $signed({1'b0, tap[y][x][23 - 8 * ch -: 8]})
                         * $signed(krow[y][16 * x +: 16]);
        end
      end
    end
  end

  // nine-tap sum, clamp to 0..255 after dropping the fraction
  logic signed [28:0] tot [3];
  logic [7:0]         chan [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = '0;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          tot[ch] = tot[ch] + 29'(prod[ch][y][x]);
        end
      end
      if (tot[ch] < 0) begin
        chan[ch] = 8'd0;
      end else if (tot[ch][28:8] > 21'd255) begin
        chan[ch] = 8'd255;
      end else begin
        chan[ch] = tot[ch][15:8];
      end
    end
    ob_rgb_nxt = s1_ctl_r.interior ? {chan[0], chan[1], chan[2]} : WHITE_RGB;
    ob_m_nxt   = ob_free ? (s1_v_r ? s1_ctl_r.emit : 4'd0) : ob_m_left;
  end

  // output register with pending result mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_m_r <= 4'd0;
    end else begin
      ob_m_r <= ob_m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      ob_rgb_r <= ob_rgb_nxt;
      ob_ctl_r <= s1_ctl_r;
    end
  end

  // result select: lowest pending kind first
  logic [23:0] o_rgb;
  logic [11:0] o_row;
  logic [9:0]  o_col;

  always_comb begin
    if (ob_m_r[EMIT_FILTERED]) begin
      o_rgb = ob_rgb_r;
      o_row = ob_ctl_r.row_m1;
      o_col = ob_ctl_r.col_m1;
    end else if (ob_m_r[EMIT_RIGHT_COL]) begin
      o_rgb = WHITE_RGB;
      o_row = ob_ctl_r.row_m1;
      o_col = ob_ctl_r.col;
    end else if (ob_m_r[EMIT_BOTTOM]) begin
      o_rgb = WHITE_RGB;
      o_row = ob_ctl_r.row;
      o_col = ob_ctl_r.col_m1;
    end else begin
      o_rgb = WHITE_RGB;
      o_row = ob_ctl_r.row;
      o_col = ob_ctl_r.col;
    end
    out_tvalid = (ob_m_r != 4'd0);
    out_tlast  = (ob_m_r == 4'b1000);
    out_tdata  = {2'b00, o_col, o_row, o_rgb[7:0], o_rgb[15:8], o_rgb[23:16]};
  end

  // checks
  a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !$onehot(ob_m_r)) |=> out_tvalid)
    else $error("pending results dropped after a handshake");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> (out_tdata[35:24] == ob_ctl_r.row && out_tdata[45:36] == ob_ctl_r.col))
    else $error("frame end flagged on a non-corner pixel");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !last_col) |=> (col_r == $past(col_r) + CW'(1)))
    else $error("column counter did not advance");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && !ob_free))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/conv_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// conv_pixel_checker: predicts and checks the filtered pixel stream
// Mirrors the register writes, runs its own 3x3 filter on each accepted
// input request and compares every output request field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_pixel_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [23:0]                    in_tdata,    // red, green, blue
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [47:0]                    out_tdata,   // red, green, blue, row, col
  input  wire logic                           out_tlast,   // frame_last
  input  wire logic                           cfg_wr_en,
  input  wire logic [rgbconv_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [rgbconv_pkg::CFG_DW-1:0] cfg_wr_data,
  output int                                  pixels_pending,
  output int                                  fail_count
);

  import rgbconv_pkg::*;

  localparam int STORE_DEPTH = 1024;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } out_pixel_t;

  // register mirror
  logic [47:0] coef_top, coef_mid, coef_bot;
  logic [10:0] width_reg;
  logic [11:0] height_reg;

  // filter state, pixels held as {red, green, blue}
  logic [23:0] older_line [STORE_DEPTH];
  logic [23:0] newer_line [STORE_DEPTH];
  logic [23:0] window_px [6];
  int unsigned row_pos, col_pos;

  out_pixel_t pixels_due[$];

  function automatic logic [7:0] clamp_sum(longint s);
    longint q;
    if (s < 0) return 8'd0;
    q = s >>> 8;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic out_pixel_t make_pixel(logic [23:0] rgb, int unsigned row,
                                            int unsigned col, logic last);
    out_pixel_t p;
    p.red   = rgb[23:16];
    p.green = rgb[15:8];
    p.blue  = rgb[7:0];
    p.row   = row[11:0];
    p.col   = col[9:0];
    p.last  = last;
    return p;
  endfunction

  // one input pixel: queue the pixels it releases and advance the state
  task automatic filter_pixel(logic [23:0] px);
    int unsigned w, h, r, c, idx;
    logic        at_last_col, at_last_row;
    logic [23:0] colv [3];
    logic [23:0] p3 [3];
    logic [23:0] filtered;
    logic [47:0] coef_row;
    longint      sums [3];
    longint      k;
    w = (width_reg < 2) ? 2 : width_reg;
    if (w > STORE_DEPTH) w = STORE_DEPTH;
    h = (height_reg < 2) ? 2 : height_reg;
    r = row_pos;
    c = col_pos;
    at_last_col = (c >= w - 1);
    at_last_row = (r >= h - 1);
    idx = c % STORE_DEPTH;
    colv[0] = older_line[idx];
    colv[1] = newer_line[idx];
    colv[2] = px;
    filtered = WHITE_RGB;
    if (r >= 2 && c >= 2) begin
      sums = '{0, 0, 0};
      for (int y = 0; y < 3; y++) begin
        coef_row = (y == 0) ? coef_top : (y == 1) ? coef_mid : coef_bot;
        p3[0] = window_px[y];
        p3[1] = window_px[3 + y];
        p3[2] = colv[y];
        for (int x = 0; x < 3; x++) begin
          k = longint'($signed(coef_row[16*x +: 16]));
          for (int ch = 0; ch < 3; ch++)
            sums[ch] += longint'(p3[x][16 - 8*ch +: 8]) * k;
        end
      end
      filtered = {clamp_sum(sums[0]), clamp_sum(sums[1]), clamp_sum(sums[2])};
    end
    // results leave in raster order
    if (r >= 1 && c >= 1) pixels_due.push_back(make_pixel(filtered, r - 1, c - 1, 1'b0));
    if (r >= 1 && at_last_col) pixels_due.push_back(make_pixel(WHITE_RGB, r - 1, c, 1'b0));
    if (at_last_row && c >= 1) pixels_due.push_back(make_pixel(WHITE_RGB, r, c - 1, 1'b0));
    if (at_last_row && at_last_col) pixels_due.push_back(make_pixel(WHITE_RGB, r, c, 1'b1));
    for (int i = 0; i < 3; i++) begin
      window_px[i] = window_px[3 + i];
      window_px[3 + i] = colv[i];
    end
    older_line[idx] = colv[1];
    newer_line[idx] = px;
    if (at_last_col) begin
      col_pos = 0;
      row_pos = at_last_row ? 0 : ((r + 1) & 12'hFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  // compare one output request with the oldest expected pixel
  task automatic check_pixel();
    out_pixel_t got, want;
    got.red   = out_tdata[7:0];
    got.green = out_tdata[15:8];
    got.blue  = out_tdata[23:16];
    got.row   = out_tdata[35:24];
    got.col   = out_tdata[45:36];
    got.last  = out_tlast;
    if (pixels_due.size() == 0) begin
      $display("%0t: unexpected output pixel, expected none, actual %h", $realtime, got);
      fail_count++;
      return;
    end
    want = pixels_due.pop_front();
    if (got.red !== want.red)
      $display("%0t: red mismatch, expected %h actual %h", $realtime, want.red, got.red);
    if (got.green !== want.green)
      $display("%0t: green mismatch, expected %h actual %h", $realtime, want.green, got.green);
    if (got.blue !== want.blue)
      $display("%0t: blue mismatch, expected %h actual %h", $realtime, want.blue, got.blue);
    if (got.row !== want.row)
      $display("%0t: row mismatch, expected %0d actual %0d", $realtime, want.row, got.row);
    if (got.col !== want.col)
      $display("%0t: col mismatch, expected %0d actual %0d", $realtime, want.col, got.col);
    if (got.last !== want.last)
      $display("%0t: frame end mismatch, expected %b actual %b", $realtime, want.last,
               got.last);
    if (got !== want) fail_count++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      coef_top   = KERNEL_TOP_RST;
      coef_mid   = KERNEL_MID_RST;
      coef_bot   = KERNEL_BOTTOM_RST;
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      window_px  = '{default: '0};
      row_pos    = 0;
      col_pos    = 0;
      fail_count = 0;
      pixels_due.delete();
    end else begin
      if (out_tvalid && out_tready) check_pixel();
      // tdata carries red in the low byte
      if (in_tvalid && in_tready) filter_pixel({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]});
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_KERNEL_TOP:    coef_top   = cfg_wr_data;
          CFG_KERNEL_MID:    coef_mid   = cfg_wr_data;
          CFG_KERNEL_BOTTOM: coef_bot   = cfg_wr_data;
          CFG_IMAGE_WIDTH:   width_reg  = cfg_wr_data[10:0];
          CFG_IMAGE_HEIGHT:  height_reg = cfg_wr_data[11:0];
          default: ;
        endcase
      end
    end
    pixels_pending = pixels_due.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_rgb_3x3_convolution.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_3x3_convolution: stimulus and verdict for the rgb 3x3 filter
// Sends directed and random frames under several kernels and geometries,
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_3x3_convolution;
  import rgbconv_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;    // red, green, blue
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;        // red, green, blue, row, col
  logic              out_tlast;        // frame_last
  logic              cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wr_data = '0;
  int                pixels_pending;
  int                fail_count;
  logic              no_idle = 1'b0;
  int                stall_left = 0;
  int                pixels_sent = 0;

  rgb_3x3_convolution u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_wr_en, .cfg_addr, .cfg_wr_data
  );

  conv_pixel_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_wr_en, .cfg_addr, .cfg_wr_data,
    .pixels_pending, .fail_count
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // quiet stretches with no idling on either side
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
  end

  // output stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_addr    = idx;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic set_kernel(logic [47:0] top, logic [47:0] mid, logic [47:0] bot);
    write_reg(CFG_KERNEL_TOP, top);
    write_reg(CFG_KERNEL_MID, mid);
    write_reg(CFG_KERNEL_BOTTOM, bot);
  endtask

  task automatic set_geometry(int w, int h);
    write_reg(CFG_IMAGE_WIDTH, 48'(w));
    write_reg(CFG_IMAGE_HEIGHT, 48'(h));
  endtask

  // hold off until every expected pixel is out, then let the pipe drain
  task automatic drain();
    in_tvalid = 1'b0;
    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one input request, driven at the falling edge
  task automatic send_pixel(logic [23:0] rgb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = rgb;
    #1;
    while (!in_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel({pick_channel(), pick_channel(), pick_channel()});
  endtask

  function automatic logic [47:0] pick_kernel_row();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    if ($urandom_range(0, 2) != 0)
      for (int i = 0; i < 3; i++)
        v[16*i +: 16] = 16'($signed($urandom_range(0, 256)) - 96);
    return v;
  endfunction

  initial begin
    int w, h;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: 3x3 frames, one interior pixel each, under several kernels
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
    drain();
    set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    for (int i = 0; i < 9; i++) send_pixel({8'hFF, 8'h01, 8'h80});
    drain();
    set_kernel({3{16'h8000}}, {16'h0000, 16'h0100, 16'h0000}, {3{16'h8000}});
    for (int i = 0; i < 9; i++) send_pixel({8'h7F, 8'hFF, 8'h00});
    drain();

    // width and height below range give a 2x2 frame, all white
    set_geometry(0, 1);
    send_pixels(4);
    drain();
    set_geometry(1, 0);
    send_pixels(4);
    drain();

    // tallest frame cut short: rows past the new height end the frame
    set_geometry(2, 4095);
    send_pixels(40);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, 48'd2);
    send_pixels(2);
    drain();

    // random kernels and small random frames
    while (pixels_sent < 150) begin
      set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_geometry(w, h);
      send_pixels(w * h * $urandom_range(1, 2));
      drain();
    end

    if (fail_count == 0 && pixels_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
